FILE: src/wildcard_pattern_match_top_assert.svh
// Assertion macros for the wildcard pattern matcher.
// Expects clk and arst_n in the scope of the module that uses them.
`ifndef WILDCARD_PATTERN_MATCH_TOP_ASSERT_SVH
`define WILDCARD_PATTERN_MATCH_TOP_ASSERT_SVH

// same-cycle implication
`define WPM_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wpm assertion failed");

// next-cycle implication
`define WPM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wpm assertion failed");

`endif

FILE: src/wpm_pkg.sv
// Package for the wildcard pattern matcher: store sizes, byte codes,
// command and result word types, sequencer states. No dependencies.
package wpm_pkg;

	localparam int PATTERN_MAX = 64;
	localparam int SUBJECT_MAX = 64;

	localparam int PAT_AW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam int SUB_AW = (SUBJECT_MAX > 1) ? $clog2(SUBJECT_MAX) : 1;
	localparam int PAT_LW = $clog2(PATTERN_MAX + 1);
	localparam int SUB_LW = $clog2(SUBJECT_MAX + 1);

	localparam logic [7:0] STAR_CODE = 8'h2A;
	localparam logic [7:0] ANY_CODE  = 8'h3F;

	typedef enum logic [1:0] {
		OP_CLR_PAT = 2'd0,
		OP_APP_PAT = 2'd1,
		OP_APP_SUB = 2'd2,
		OP_EVAL    = 2'd3
	} wpm_op_t;

	typedef struct packed {
		wpm_op_t    op;
		logic [7:0] char_code;
	} wpm_cmd_t;

	typedef struct packed {
		logic matched;
		logic overflowed;
	} wpm_result_t;

	// evaluate request from the store bookkeeping to the sequencer
	typedef struct packed {
		logic              go;
		logic              ovf;
		logic [PAT_LW-1:0] plen;
		logic [SUB_LW-1:0] slen;
	} wpm_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAIN_RD,
		ST_MAIN_EX,
		ST_SCAN_RD,
		ST_SCAN_EX,
		ST_TAIL_RD,
		ST_TAIL_EX
	} wpm_state_t;

endpackage

FILE: src/wpm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wpm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: src/wpm_seq.sv
// Match sequencer: walks pattern and subject stores with star backtracking
// and registers the result word. Depends on wpm_pkg and the assertion header.
`include "wildcard_pattern_match_top_assert.svh"

module wpm_seq (
	input  logic                      clk,
	input  logic                      arst_n,
	input  wpm_pkg::wpm_req_t         req,
	input  logic [7:0]                pdata,
	input  logic [7:0]                sdata,
	output logic [wpm_pkg::PAT_AW-1:0] paddr,
	output logic [wpm_pkg::SUB_AW-1:0] saddr,
	output logic                      busy,
	output logic                      finish,
	output logic                      done,
	output wpm_pkg::wpm_result_t      result
);
	import wpm_pkg::*;

	wpm_state_t        state_q, state_d;
	logic [PAT_LW-1:0] pi_q, pi_d, mk_p_q, mk_p_d;
	logic [SUB_LW-1:0] si_q, si_d, mk_s_q, mk_s_d;
	logic              mark_q, mark_d;
	logic              done_q, done_d;
	wpm_result_t       res_q, res_d;
	logic              p_lt, s_lt;

	assign p_lt   = pi_q < req.plen;
	assign s_lt   = si_q < req.slen;
	assign paddr  = pi_q[PAT_AW-1:0];
	assign saddr  = si_q[SUB_AW-1:0];
	assign busy   = state_q != ST_IDLE;
	assign finish = done_d;
	assign done   = done_q;
	assign result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mark_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			mark_q  <= mark_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		pi_q   <= pi_d;
		si_q   <= si_d;
		mk_p_q <= mk_p_d;
		mk_s_q <= mk_s_d;
		res_q  <= res_d;
	end

	always_comb begin
		state_d = state_q;
		pi_d    = pi_q;
		si_d    = si_q;
		mk_p_d  = mk_p_q;
		mk_s_d  = mk_s_q;
		mark_d  = mark_q;
		done_d  = 1'b0;
		res_d   = res_q;
		case (state_q)
			ST_IDLE: begin
				if (req.go) begin
					if (req.ovf) begin
						done_d           = 1'b1;
						res_d.matched    = 1'b0;
						res_d.overflowed = 1'b1;
					end else begin
						pi_d    = '0;
						si_d    = '0;
						mark_d  = 1'b0;
						state_d = ST_MAIN_RD;
					end
				end
			end
			ST_MAIN_RD: begin
				if (s_lt && p_lt) begin
					state_d = ST_MAIN_EX;
				end else if (s_lt) begin
					done_d           = 1'b1;
					res_d.matched    = 1'b0;
					res_d.overflowed = 1'b0;
					state_d          = ST_IDLE;
				end else begin
					state_d = ST_TAIL_RD;
				end
			end
			ST_MAIN_EX: begin
				if (pdata == STAR_CODE) begin
					pi_d    = pi_q + 1'b1;
					state_d = ST_SCAN_RD;
				end else if (pdata == ANY_CODE || pdata == sdata) begin
					pi_d    = pi_q + 1'b1;
					si_d    = si_q + 1'b1;
					state_d = ST_MAIN_RD;
				end else if (mark_q) begin
					// backtrack to the last star, one subject byte further on
					pi_d    = mk_p_q;
					si_d    = mk_s_q;
					mark_d  = 1'b0;
					state_d = ST_MAIN_RD;
				end else begin
					done_d           = 1'b1;
					res_d.matched    = 1'b0;
					res_d.overflowed = 1'b0;
					state_d          = ST_IDLE;
				end
			end
			ST_SCAN_RD: begin
				if (!s_lt) begin
					state_d = ST_MAIN_RD;
				end else if (!p_lt) begin
					// star at pattern end swallows the rest of the subject
					si_d    = req.slen;
					state_d = ST_MAIN_RD;
				end else begin
					state_d = ST_SCAN_EX;
				end
			end
			ST_SCAN_EX: begin
				if (sdata != pdata) begin
					si_d    = si_q + 1'b1;
					state_d = ST_SCAN_RD;
				end else begin
					mark_d  = 1'b1;
					mk_s_d  = si_q + 1'b1;
					mk_p_d  = pi_q - 1'b1;
					state_d = ST_MAIN_RD;
				end
			end
			ST_TAIL_RD: begin
				if (p_lt) begin
					state_d = ST_TAIL_EX;
				end else begin
					done_d           = 1'b1;
					res_d.matched    = 1'b1;
					res_d.overflowed = 1'b0;
					state_d          = ST_IDLE;
				end
			end
			ST_TAIL_EX: begin
				if (pdata == STAR_CODE) begin
					pi_d    = pi_q + 1'b1;
					state_d = ST_TAIL_RD;
				end else begin
					done_d           = 1'b1;
					res_d.matched    = 1'b0;
					res_d.overflowed = 1'b0;
					state_d          = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`WPM_ASSERT_NOW(a_done_idle, done, !busy)
	`WPM_ASSERT_NOW(a_ovf_nomatch, done && result.overflowed, !result.matched)
	`WPM_ASSERT_NOW(a_pi_bound, busy, pi_q <= req.plen)
	`WPM_ASSERT_NOW(a_si_bound, busy, si_q <= req.slen)
	`WPM_ASSERT_NXT(a_go_progress, req.go && !busy, busy || done)

endmodule

FILE: src/wildcard_pattern_match_top.sv
// Wildcard pattern matcher top level: store bookkeeping, pattern and
// subject RAMs, match sequencer. Depends on wpm_pkg, wpm_ram, wpm_seq.
// Clear and append words leave busy low, so they go back to back. Evaluate on stores
// without overflow holds busy high while the sequencer walks them; each byte compare
// reads the RAMs, then compares on the registered RAM data. With an overflowed store
// busy stays low and done comes in the cycle after the evaluate word. The next word
// is taken in the done cycle, and the receiver cannot stall. Reset clears lengths,
// overflow flags and the sequencer; store contents are undefined until written.
module wildcard_pattern_match_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  wpm_pkg::wpm_cmd_t    cmd,
	output logic                 busy,
	output logic                 done,
	output wpm_pkg::wpm_result_t result
);
	import wpm_pkg::*;

	logic [PAT_LW-1:0] plen_q;
	logic [SUB_LW-1:0] slen_q;
	logic              povf_q, sovf_q;
	logic              accept, pat_full, sub_full, pat_we, sub_we;
	logic              finish;
	logic [PAT_AW-1:0] paddr;
	logic [SUB_AW-1:0] saddr;
	logic [7:0]        pdata, sdata;
	wpm_req_t          req;

	assign accept   = start && !busy;
	assign pat_full = plen_q == PAT_LW'(PATTERN_MAX);
	assign sub_full = slen_q == SUB_LW'(SUBJECT_MAX);
	assign pat_we   = accept && cmd.op == OP_APP_PAT && !pat_full;
	assign sub_we   = accept && cmd.op == OP_APP_SUB && !sub_full;

	assign req.go   = accept && cmd.op == OP_EVAL;
	assign req.ovf  = povf_q || sovf_q;
	assign req.plen = plen_q;
	assign req.slen = slen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q <= '0;
			slen_q <= '0;
			povf_q <= 1'b0;
			sovf_q <= 1'b0;
		end else begin
			if (accept && cmd.op == OP_CLR_PAT) begin
				plen_q <= '0;
				povf_q <= 1'b0;
			end else if (accept && cmd.op == OP_APP_PAT) begin
				if (pat_full) begin
					povf_q <= 1'b1;
				end else begin
					plen_q <= plen_q + 1'b1;
				end
			end
			// drop the subject once its result is formed
			if (finish) begin
				slen_q <= '0;
				sovf_q <= 1'b0;
			end else if (accept && cmd.op == OP_APP_SUB) begin
				if (sub_full) begin
					sovf_q <= 1'b1;
				end else begin
					slen_q <= slen_q + 1'b1;
				end
			end
		end
	end

	wpm_ram #(
		.WIDTH(8),
		.DEPTH(PATTERN_MAX)
	) u_pat_ram (
		.clk  (clk),
		.we   (pat_we),
		.waddr(plen_q[PAT_AW-1:0]),
		.wdata(cmd.char_code),
		.raddr(paddr),
		.rdata(pdata)
	);

	wpm_ram #(
		.WIDTH(8),
		.DEPTH(SUBJECT_MAX)
	) u_sub_ram (
		.clk  (clk),
		.we   (sub_we),
		.waddr(slen_q[SUB_AW-1:0]),
		.wdata(cmd.char_code),
		.raddr(saddr),
		.rdata(sdata)
	);

	wpm_seq u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.pdata (pdata),
		.sdata (sdata),
		.paddr (paddr),
		.saddr (saddr),
		.busy  (busy),
		.finish(finish),
		.done  (done),
		.result(result)
	);

endmodule

FILE: tb/wildcard_pattern_match_top_tb.sv
// Self-checking testbench for wildcard_pattern_match_top: directed table, then random
// load/evaluate sequences, each result checked against a behavioral glob matcher or,
// for typed rows, the table's word. Depends on wpm_pkg and the RTL under src.
module wildcard_pattern_match_top_tb;
	import wpm_pkg::*;

	localparam int RANDOM_WORDS = 2000;
	localparam int STALL_LIMIT  = 40000;
	localparam int SETTLE_CYCLES = 40;

	typedef struct packed {
		wpm_op_t    op;
		logic [7:0] code;
		logic [6:0] reps;
		logic       typed;
		logic       t_matched;
		logic       t_ovf;
	} dir_row_t;

	localparam int DIR_ROWS = 24;
	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		'{OP_EVAL,    8'hFF, 7'd1,  1'b1, 1'b1, 1'b0}, // empty pattern, empty subject
		'{OP_APP_PAT, 8'h2A, 7'd1,  1'b0, 1'b0, 1'b0},
		'{OP_EVAL,    8'h00, 7'd1,  1'b0, 1'b0, 1'b0}, // lone star, empty subject
		'{OP_APP_SUB, 8'h00, 7'd1,  1'b0, 1'b0, 1'b0},
		'{OP_APP_SUB, 8'hFF, 7'd1,  1'b0, 1'b0, 1'b0},
		'{OP_EVAL,    8'h00, 7'd1,  1'b0, 1'b0, 1'b0},
		'{OP_CLR_PAT, 8'h00, 7'd1,  1'b0, 1'b0, 1'b0},
		'{OP_APP_PAT, 8'h3F, 7'd1,  1'b0, 1'b0, 1'b0},
		'{OP_APP_PAT, 8'hFF, 7'd1,  1'b0, 1'b0, 1'b0},
		'{OP_APP_SUB, 8'h41, 7'd1,  1'b0, 1'b0, 1'b0},
		'{OP_APP_SUB, 8'hFF, 7'd1,  1'b0, 1'b0, 1'b0},
		'{OP_EVAL,    8'h00, 7'd1,  1'b0, 1'b0, 1'b0},
		'{OP_CLR_PAT, 8'h55, 7'd1,  1'b0, 1'b0, 1'b0},
		'{OP_APP_PAT, 8'h2A, 7'd1,  1'b0, 1'b0, 1'b0},
		'{OP_APP_PAT, 8'h3F, 7'd1,  1'b0, 1'b0, 1'b0}, // '?' after a star is literal
		'{OP_APP_SUB, 8'h61, 7'd1,  1'b0, 1'b0, 1'b0},
		'{OP_APP_SUB, 8'h62, 7'd1,  1'b0, 1'b0, 1'b0},
		'{OP_EVAL,    8'h00, 7'd1,  1'b0, 1'b0, 1'b0},
		'{OP_APP_SUB, 8'h00, 7'd70, 1'b0, 1'b0, 1'b0}, // overrun the subject store
		'{OP_EVAL,    8'h00, 7'd1,  1'b1, 1'b0, 1'b1},
		'{OP_APP_PAT, 8'hAA, 7'd70, 1'b0, 1'b0, 1'b0}, // overrun the pattern store
		'{OP_EVAL,    8'h00, 7'd1,  1'b1, 1'b0, 1'b1},
		'{OP_CLR_PAT, 8'h00, 7'd1,  1'b0, 1'b0, 1'b0},
		'{OP_EVAL,    8'hFF, 7'd1,  1'b1, 1'b1, 1'b0}
	};

	logic        clk;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	wpm_cmd_t    cmd = '0;
	logic        busy;
	logic        done;
	wpm_result_t result;

	// predictor state
	logic [7:0] pat_bytes [PATTERN_MAX];
	logic [7:0] sub_bytes [SUBJECT_MAX];
	int         pat_len = 0;
	int         sub_len = 0;
	bit         pat_ovf = 1'b0;
	bit         sub_ovf = 1'b0;

	wpm_result_t pending_results [$];
	int          mismatch_count = 0;
	int          words_sent = 0;
	int          results_seen = 0;
	int          hits_seen = 0;
	int          ovf_seen = 0;
	int          stall_cycles = 0;
	int          next_gap = 0;
	bit          no_idle = 1'b0;

	wildcard_pattern_match_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic bit glob_hit();
		int         pi;
		int         si;
		int         mark_s;
		int         mark_p;
		bit         have_mark;
		logic [7:0] pc;
		pi = 0;
		si = 0;
		mark_s = 0;
		mark_p = 0;
		have_mark = 1'b0;
		while (si < sub_len && pi < pat_len) begin
			pc = pat_bytes[pi];
			if (pc == STAR_CODE) begin
				pi++;
				// scan for the next pattern byte taken literally
				while (si < sub_len && (pi >= pat_len || sub_bytes[si] != pat_bytes[pi]))
					si++;
				if (si < sub_len) begin
					have_mark = 1'b1;
					mark_s = si + 1;
					mark_p = pi - 1;
				end
			end else if (pc == ANY_CODE) begin
				pi++;
				si++;
			end else if (pc != sub_bytes[si]) begin
				if (!have_mark)
					return 1'b0;
				si = mark_s;
				pi = mark_p;
				have_mark = 1'b0;
			end else begin
				pi++;
				si++;
			end
		end
		if (si < sub_len)
			return 1'b0;
		while (pi < pat_len && pat_bytes[pi] == STAR_CODE)
			pi++;
		return pi >= pat_len;
	endfunction

	// update the predicted stores for one word; returns 1 when it yields a result
	function automatic bit apply_word(input wpm_cmd_t w, output wpm_result_t r);
		bit has_res;
		has_res = 1'b0;
		r = '0;
		case (w.op)
			OP_CLR_PAT: begin
				pat_len = 0;
				pat_ovf = 1'b0;
			end
			OP_APP_PAT: begin
				if (pat_len < PATTERN_MAX) begin
					pat_bytes[pat_len] = w.char_code;
					pat_len++;
				end else
					pat_ovf = 1'b1;
			end
			OP_APP_SUB: begin
				if (sub_len < SUBJECT_MAX) begin
					sub_bytes[sub_len] = w.char_code;
					sub_len++;
				end else
					sub_ovf = 1'b1;
			end
			OP_EVAL: begin
				r.overflowed = pat_ovf | sub_ovf;
				r.matched = r.overflowed ? 1'b0 : glob_hit();
				sub_len = 0;
				sub_ovf = 1'b0;
				has_res = 1'b1;
			end
			default: ;
		endcase
		return has_res;
	endfunction

	function automatic int idle_len();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_word(input wpm_cmd_t w, input bit typed, input wpm_result_t tres);
		wpm_result_t r;
		repeat (next_gap) @(posedge clk);
		start <= 1'b1;
		cmd <= w;
		do @(negedge clk); while (busy);
		@(posedge clk);
		if (apply_word(w, r))
			pending_results.push_back(typed ? tres : r);
		words_sent++;
		// drop start now unless the next word follows back to back
		next_gap = idle_len();
		if (next_gap > 0)
			start <= 1'b0;
	endtask

	task automatic send_plain(input wpm_op_t op, input logic [7:0] code);
		wpm_cmd_t w;
		w.op = op;
		w.char_code = code;
		send_word(w, 1'b0, '0);
	endtask

	// hold the sender until every evaluate has answered
	task automatic hold_sender();
		if (next_gap == 0)
			start <= 1'b0;
		next_gap = 0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	function automatic logic [7:0] pattern_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 20)
			return STAR_CODE;
		if (r < 35)
			return ANY_CODE;
		if (r < 85)
			return 8'h61 + 8'($urandom_range(0, 2));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] subject_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return 8'h61 + 8'($urandom_range(0, 2));
		if (r < 80)
			return STAR_CODE;
		if (r < 85)
			return ANY_CODE;
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic random_sequence();
		int         kind;
		int         plen;
		int         n;
		logic [7:0] pat_plan [$];
		logic [7:0] b;
		kind = $urandom_range(0, 99);
		no_idle = ($urandom_range(0, 3) == 0);
		if (kind < 70) begin
			if ($urandom_range(0, 99) < 85)
				send_plain(OP_CLR_PAT, 8'($urandom_range(0, 255)));
			plen = ($urandom_range(0, 99) < 4) ? PATTERN_MAX : $urandom_range(0, 10);
			repeat (plen) begin
				b = pattern_byte();
				pat_plan.push_back(b);
				send_plain(OP_APP_PAT, b);
			end
			if ($urandom_range(0, 1)) begin
				// expand the pattern into a subject, with the odd literal spoiled
				foreach (pat_plan[i]) begin
					if (pat_plan[i] == STAR_CODE) begin
						repeat ($urandom_range(0, 3)) send_plain(OP_APP_SUB, subject_byte());
					end else if (pat_plan[i] == ANY_CODE || $urandom_range(0, 99) < 10) begin
						send_plain(OP_APP_SUB, subject_byte());
					end else
						send_plain(OP_APP_SUB, pat_plan[i]);
				end
			end else begin
				n = (plen == PATTERN_MAX) ? SUBJECT_MAX : $urandom_range(0, 12);
				repeat (n) send_plain(OP_APP_SUB, subject_byte());
			end
			send_plain(OP_EVAL, 8'($urandom_range(0, 255)));
		end else if (kind < 85) begin
			repeat ($urandom_range(0, 10)) send_plain(OP_APP_SUB, subject_byte());
			send_plain(OP_EVAL, 8'($urandom_range(0, 255)));
		end else if (kind < 90) begin
			n = SUBJECT_MAX + $urandom_range(1, 4);
			if ($urandom_range(0, 1)) begin
				repeat (n) send_plain(OP_APP_PAT, pattern_byte());
			end else begin
				repeat (n) send_plain(OP_APP_SUB, subject_byte());
			end
			send_plain(OP_EVAL, 8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(1, 6))
				send_plain(wpm_op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
		end
		if ($urandom_range(0, 99) < 5)
			hold_sender();
	endtask

	initial begin : stimulus
		wpm_cmd_t    w;
		wpm_result_t tres;
		int          random_base;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (int row = 0; row < DIR_ROWS; row++) begin
			repeat (DIRECTED[row].reps) begin
				w.op = DIRECTED[row].op;
				w.char_code = DIRECTED[row].code;
				tres.matched = DIRECTED[row].t_matched;
				tres.overflowed = DIRECTED[row].t_ovf;
				send_word(w, DIRECTED[row].typed, tres);
			end
		end
		hold_sender();

		random_base = words_sent;
		while (words_sent - random_base < RANDOM_WORDS)
			random_sequence();

		hold_sender();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Covered %0d command words and %0d evaluate answers (%0d hits, %0d overflow).",
			words_sent, results_seen, hits_seen, ovf_seen);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	always @(negedge clk) begin : result_check
		wpm_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result word with nothing expected: matched %0d overflowed %0d",
					result.matched, result.overflowed);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				results_seen++;
				if (result.matched)
					hits_seen++;
				if (result.overflowed)
					ovf_seen++;
				if (result.matched !== want.matched) begin
					$error("matched: expected %0d, got %0d", want.matched, result.matched);
					mismatch_count++;
				end
				if (result.overflowed !== want.overflowed) begin
					$error("overflowed: expected %0d, got %0d", want.overflowed,
						result.overflowed);
					mismatch_count++;
				end
			end
		end
	end

	// count cycles in which no word moves in either direction
	always @(negedge clk) begin
		if (!arst_n || done || (start && !busy))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Timeout after %0d idle cycles", stall_cycles);
			$display("Mismatches found");
			$finish;
		end
	end

endmodule

FILE: sim.f
+incdir+src
src/wpm_pkg.sv
src/wpm_ram.sv
src/wpm_seq.sv
src/wildcard_pattern_match_top.sv
tb/wildcard_pattern_match_top_tb.sv
